[src/rmt_pkg.sv]
package rmt_pkg;

    // Sample and result types
    typedef logic signed [31:0] sample_t;
    typedef logic signed [32:0] median_t;

    // Chain operation codes
    typedef logic [1:0] chain_op_t;

    localparam chain_op_t OP_HOLD   = 2'd0;
    localparam chain_op_t OP_INSERT = 2'd1;  // ordered insert, chain grows by one
    localparam chain_op_t OP_PUSH   = 2'd2;  // new head, everything moves back one
    localparam chain_op_t OP_POPINS = 2'd3;  // drop head and insert, length kept

    // Command broadcast to every cell of one chain
    typedef struct packed {
        chain_op_t op;
        sample_t   x;
    } chain_ctl_t;

endpackage

[src/rmt_cell.sv]
module rmt_cell #(
    parameter bit DESC  = 1'b0,
    parameter bit FIRST = 1'b0
) (
    input  logic               clk,
    input  rmt_pkg::chain_ctl_t ctl,
    input  logic               valid,
    input  rmt_pkg::sample_t   left_val,
    input  logic               left_b,
    input  rmt_pkg::sample_t   right_val,
    input  logic               right_p,
    output rmt_pkg::sample_t   val,
    output logic               b_out,
    output logic               p_out
);
    import rmt_pkg::*;

    sample_t val_reg;
    sample_t val_next;
    logic    x_before;

    // Does the broadcast value sort ahead of this cell's value
    assign x_before = DESC ? (ctl.x > val_reg) : (ctl.x < val_reg);
    assign b_out    = valid && x_before;
    assign p_out    = valid && !x_before;
    assign val      = val_reg;

    // Next value from the neighbors, the broadcast value or self
    always_comb
    begin
        case (ctl.op)
            OP_INSERT:
            begin
                if (left_b)
                    val_next = left_val;
                else if (x_before || !valid)
                    val_next = ctl.x;
                else
                    val_next = val_reg;
            end
            OP_PUSH:
            begin
                val_next = FIRST ? ctl.x : left_val;
            end
            OP_POPINS:
            begin
                if (right_p)
                    val_next = right_val;
                else if (FIRST || p_out)
                    val_next = ctl.x;
                else
                    val_next = val_reg;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[src/rmt_chain.sv]
module rmt_chain #(
    parameter int DEPTH = 128,
    parameter bit DESC  = 1'b0
) (
    input  logic                         clk,
    input  rmt_pkg::chain_ctl_t          ctl,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    output rmt_pkg::sample_t             head
);
    import rmt_pkg::*;

    localparam int CNTW = $clog2(DEPTH + 1);

    sample_t    vals [DEPTH];
    logic [DEPTH-1:0] bv;
    logic [DEPTH-1:0] pv;

    // Row of cells; cell 0 holds the head of the ordering
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sample_t lv;
        sample_t rv;
        logic    lb;
        logic    rp;

        if (i == 0)
        begin : g_first
            assign lv = '0;
            assign lb = 1'b0;
        end
        else
        begin : g_mid
            assign lv = vals[i-1];
            assign lb = bv[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rv = '0;
            assign rp = 1'b0;
        end
        else
        begin : g_more
            assign rv = vals[i+1];
            assign rp = pv[i+1];
        end

        rmt_cell #(
            .DESC  (DESC),
            .FIRST (i == 0)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .valid     (count > CNTW'(i)),
            .left_val  (lv),
            .left_b    (lb),
            .right_val (rv),
            .right_p   (rp),
            .val       (vals[i]),
            .b_out     (bv[i]),
            .p_out     (pv[i])
        );
    end

    assign head = vals[0];

endmodule

[src/running_median_tracker.sv]
// Channel   Handshake             Payload
// -------   -------------------   ------------------------------------------
// in        in_valid / in_stall   start_new, sample
// out       out_valid / out_stall median_twice, held_count, full_flag
//
// One sample per cycle while the input is not stalled. The transfer edge
// itself writes the two cell chains and the pending stage; the median add
// from the chain heads enters the output register as the pending stage moves.
// Reset clears the counts and the pipeline flags; cell contents need none.
// A stalled output stalls the input only once a result is also pending.
module running_median_tracker #(
    parameter int CAPACITY = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            start_new,
    input  rmt_pkg::sample_t                sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rmt_pkg::median_t                median_twice,
    output logic [$clog2(CAPACITY+1)-1:0]   held_count,
    output logic                            full_flag
);
    import rmt_pkg::*;

    // Lower half kept descending, upper half ascending
    localparam int LCAP = (CAPACITY + 1) / 2;
    localparam int UCAP = CAPACITY / 2;
    localparam int LW   = $clog2(LCAP + 1);
    localparam int UW   = $clog2(UCAP + 1);
    localparam int CW   = $clog2(CAPACITY + 1);

    logic [LW-1:0] nl_reg, nl_next, nl_eff;
    logic [UW-1:0] nu_reg, nu_next, nu_eff;
    logic [CW-1:0] total_eff;

    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_cnt_reg, pend_cnt_next;
    logic          pend_full_reg, pend_full_next;

    logic          out_valid_reg, out_valid_next;
    median_t       median_reg, median_next;
    logic [CW-1:0] held_reg, held_next;
    logic          full_reg, full_next;

    chain_ctl_t    lo_ctl, hi_ctl;
    sample_t       lo_head, hi_head;

    logic          in_xfer;
    logic          pend_move;
    logic          is_full;
    logic          balanced;
    logic          to_lower;

    // Handshake
    assign pend_move = pend_reg && !(out_valid_reg && out_stall);
    assign in_stall  = pend_reg && out_valid_reg && out_stall;
    assign in_xfer   = in_valid && !in_stall;

    // Counts as seen by this sample, after a start empties the store
    assign nl_eff    = start_new ? '0 : nl_reg;
    assign nu_eff    = start_new ? '0 : nu_reg;
    assign total_eff = CW'(nl_eff) + CW'(nu_eff);
    assign is_full   = (total_eff == CW'(CAPACITY));
    assign balanced  = (nl_eff == LW'(nu_eff));
    assign to_lower  = (nl_eff == '0) || (sample <= lo_head);

    // Chain commands and count update
    always_comb
    begin
        lo_ctl.op = OP_HOLD;
        lo_ctl.x  = sample;
        hi_ctl.op = OP_HOLD;
        hi_ctl.x  = sample;
        nl_next   = nl_reg;
        nu_next   = nu_reg;
        if (in_xfer)
        begin
            nl_next = nl_eff;
            nu_next = nu_eff;
            if (!is_full)
            begin
                if (balanced)
                begin
                    nl_next = nl_eff + 1'b1;
                    if (to_lower)
                    begin
                        lo_ctl.op = OP_INSERT;
                    end
                    else if ((nu_eff == '0) || (sample <= hi_head))
                    begin
                        lo_ctl.op = OP_PUSH;
                    end
                    else
                    begin
                        lo_ctl.op = OP_PUSH;
                        lo_ctl.x  = hi_head;
                        hi_ctl.op = OP_POPINS;
                    end
                end
                else
                begin
                    nu_next = nu_eff + 1'b1;
                    if (sample > lo_head)
                    begin
                        hi_ctl.op = OP_INSERT;
                    end
                    else
                    begin
                        hi_ctl.op = OP_PUSH;
                        hi_ctl.x  = lo_head;
                        lo_ctl.op = OP_POPINS;
                    end
                end
            end
        end
    end

    rmt_chain #(
        .DEPTH (LCAP),
        .DESC  (1'b1)
    ) u_lo_chain (
        .clk   (clk),
        .ctl   (lo_ctl),
        .count (nl_eff),
        .head  (lo_head)
    );

    rmt_chain #(
        .DEPTH (UCAP),
        .DESC  (1'b0)
    ) u_hi_chain (
        .clk   (clk),
        .ctl   (hi_ctl),
        .count (nu_eff),
        .head  (hi_head)
    );

    // Pending stage: waits for the chains to settle
    always_comb
    begin
        pend_next      = pend_reg;
        pend_cnt_next  = pend_cnt_reg;
        pend_full_next = pend_full_reg;
        if (pend_move)
            pend_next = 1'b0;
        if (in_xfer)
        begin
            pend_next      = 1'b1;
            pend_cnt_next  = total_eff + CW'(!is_full);
            pend_full_next = is_full;
        end
    end

    // Output stage: median from the chain heads
    always_comb
    begin
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        held_next      = held_reg;
        full_next      = full_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
            held_next      = pend_cnt_reg;
            full_next      = pend_full_reg;
            if (pend_cnt_reg[0])
                median_next = {lo_head[31], lo_head} + {lo_head[31], lo_head};
            else
                median_next = {lo_head[31], lo_head} + {hi_head[31], hi_head};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_reg        <= '0;
            nu_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nl_reg        <= nl_next;
            nu_reg        <= nu_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_cnt_reg  <= pend_cnt_next;
        pend_full_reg <= pend_full_next;
        median_reg    <= median_next;
        held_reg      <= held_next;
        full_reg      <= full_next;
    end

    assign out_valid    = out_valid_reg;
    assign median_twice = median_reg;
    assign held_count   = held_reg;
    assign full_flag    = full_reg;

endmodule

[src/rmt_checker.sv]
module rmt_checker #(
    parameter int CAPACITY = 256
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            start_new,
    input rmt_pkg::sample_t                sample,
    input logic                            out_valid,
    input logic                            out_stall,
    input rmt_pkg::median_t                median_twice,
    input logic [$clog2(CAPACITY+1)-1:0]   held_count,
    input logic                            full_flag
);
    import rmt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median_twice)
            && $stable(held_count) && $stable(full_flag))
        else $error("result changed while stalled");

    // The store is never empty after a transfer
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> held_count != '0)
        else $error("result reports an empty store");

    // A dropped sample means the store is at capacity
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_flag |-> held_count == CW'(CAPACITY))
        else $error("full flag without a full store");

    // Input is only held off while a finished result waits
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |-> !in_stall)
        else $error("input stalled with output free");

endmodule

bind running_median_tracker rmt_checker #(.CAPACITY(CAPACITY)) u_rmt_checker (.*);

[tb/sv/median_checker.sv]
// Watches both channels of the running median tracker, keeps its own sorted
// store of the held samples and compares every output transfer with the
// oldest predicted result.
module median_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            start_new,
    input  rmt_pkg::sample_t                sample,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  rmt_pkg::median_t                median_twice,
    input  logic [$clog2(CAPACITY+1)-1:0]   held_count,
    input  logic                            full_flag,
    output int                              fail_count,
    output int                              medians_owed
);
    import rmt_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);

    typedef struct packed {
        median_t         med;
        logic [CW-1:0]   cnt;
        logic            full;
    } median_rec_t;

    // Ascending copy of the held samples, entries 0 .. held_n-1 valid
    sample_t     held_vals [CAPACITY];
    int          held_n;
    median_rec_t pending_medians [$];
    median_rec_t want;

    // Insert one sample (or drop it on a full store) and work out the result
    task automatic track_sample(input logic strt, input sample_t val,
                                output median_rec_t rec);
        int pos;
        if (strt)
            held_n = 0;
        rec.full = 1'b0;
        if (held_n >= CAPACITY)
            rec.full = 1'b1;
        else
        begin
            // equal samples stay ahead of the new one
            pos = held_n;
            while (pos > 0 && held_vals[pos-1] > val)
            begin
                held_vals[pos] = held_vals[pos-1];
                pos--;
            end
            held_vals[pos] = val;
            held_n++;
        end
        if (held_n % 2 == 1)
            rec.med = median_t'(held_vals[held_n/2]) + median_t'(held_vals[held_n/2]);
        else
            rec.med = median_t'(held_vals[held_n/2-1]) + median_t'(held_vals[held_n/2]);
        rec.cnt = CW'(held_n);
    endtask

    initial
    begin
        fail_count = 0;
        held_n     = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_medians.delete();
            held_n = 0;
            medians_owed <= 0;
        end
        else
        begin
            // output transfer: compare with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pending_medians.size() == 0)
                begin
                    $error("result transfer with nothing expected: median_twice %0d",
                           median_twice);
                    fail_count++;
                end
                else
                begin
                    want = pending_medians.pop_front();
                    if (median_twice !== want.med)
                    begin
                        $error("median_twice: expected %0d, got %0d", want.med, median_twice);
                        fail_count++;
                    end
                    if (held_count !== want.cnt)
                    begin
                        $error("held_count: expected %0d, got %0d", want.cnt, held_count);
                        fail_count++;
                    end
                    if (full_flag !== want.full)
                    begin
                        $error("full_flag: expected %0b, got %0b", want.full, full_flag);
                        fail_count++;
                    end
                end
            end
            // input transfer: predict its result
            if (in_valid && !in_stall)
            begin
                track_sample(start_new, sample, want);
                pending_medians.insert(pending_medians.size(), want);
            end
            medians_owed <= pending_medians.size();
        end
    end

endmodule

[tb/sv/tb_running_median_tracker.sv]
module tb_running_median_tracker;
    import rmt_pkg::*;

    localparam int CAPACITY   = 256;
    localparam int CW         = $clog2(CAPACITY+1);
    localparam int NUM_ITEMS  = 950;
    localparam int QUIET_MAX  = 2000;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic            start_new;
    sample_t         sample;
    logic            out_valid;
    logic            out_stall;
    median_t         median_twice;
    logic [CW-1:0]   held_count;
    logic            full_flag;

    int fail_count;
    int medians_owed;
    int quiet_cycles;
    int burst_left;
    int sent;

    running_median_tracker #(.CAPACITY(CAPACITY)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_new    (start_new),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_twice (median_twice),
        .held_count   (held_count),
        .full_flag    (full_flag)
    );

    median_checker #(.CAPACITY(CAPACITY)) u_median_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_new    (start_new),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_twice (median_twice),
        .held_count   (held_count),
        .full_flag    (full_flag),
        .fail_count   (fail_count),
        .medians_owed (medians_owed)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Sample value: extremes, a narrow band for ties, or anything
    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return sample_t'(32'h8000_0000);
        else if (r == 1)
            return sample_t'(32'h7fff_ffff);
        else if (r < 5)
            return sample_t'($urandom_range(0, 16)) - sample_t'(8);
        else
            return sample_t'($urandom);
    endfunction

    // One input transfer, with a random gap ahead of it
    task automatic send_sample(input logic strt, input sample_t val);
        int gap;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(20, 60);
            if ($urandom_range(0, 99) >= 55)
                gap = idle_len();
        end
        if (gap > 0)
        begin
            in_valid  <= 1'b0;
            start_new <= 1'($urandom_range(0, 1));
            sample    <= sample_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_new <= strt;
        sample    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Output stall pattern: free runs alternating with stalls
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 300)) @(posedge clk);
            else
                repeat ($urandom_range(1, 24)) @(posedge clk);
            out_stall <= 1'b1;
            repeat (idle_len()) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any transfer
    initial quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("FAIL running_median_tracker");
                $finish;
            end
        end
    end

    initial
    begin
        int run_len;
        logic first_run;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        start_new  = 1'b0;
        sample     = '0;
        burst_left = 0;
        sent       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, mixed signs, ties, largest and smallest sums
        send_sample(1'b1, sample_t'(32'h8000_0000));
        send_sample(1'b0, sample_t'(32'h7fff_ffff));
        send_sample(1'b0, sample_t'(0));
        send_sample(1'b0, sample_t'(-1));
        send_sample(1'b0, sample_t'(1));
        send_sample(1'b1, sample_t'(7));
        send_sample(1'b0, sample_t'(7));
        send_sample(1'b0, sample_t'(7));
        send_sample(1'b0, sample_t'(-7));
        send_sample(1'b0, sample_t'(7));
        send_sample(1'b1, sample_t'(32'h7fff_ffff));
        send_sample(1'b0, sample_t'(32'h7fff_ffff));
        send_sample(1'b1, sample_t'(32'h8000_0000));
        send_sample(1'b0, sample_t'(32'h8000_0000));
        send_sample(1'b0, sample_t'(32'h8000_0000));
        send_sample(1'b1, sample_t'(32'h5555_5555));
        send_sample(1'b0, sample_t'(32'haaaa_aaaa));
        send_sample(1'b0, sample_t'(32'h0000_ffff));
        send_sample(1'b0, sample_t'(32'hffff_0000));

        // Random runs; some long enough to fill the store and overflow it
        first_run = 1'b1;
        while (sent < NUM_ITEMS)
        begin
            if (first_run || $urandom_range(0, 4) == 0)
                run_len = $urandom_range(CAPACITY + 1, CAPACITY + 20);
            else
                run_len = $urandom_range(1, 30);
            first_run = 1'b0;
            for (int i = 0; i < run_len && sent < NUM_ITEMS; i++)
            begin
                // an occasional stray start breaks a short run
                if (i == 0)
                    send_sample(1'b1, pick_sample());
                else
                    send_sample(run_len <= 30 && $urandom_range(0, 59) == 0,
                                pick_sample());
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain, then keep watching for stray results before the verdict
        while (medians_owed != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS running_median_tracker");
        else
            $display("FAIL running_median_tracker");
        $finish;
    end

endmodule

[running_median_tracker.f]
src/rmt_pkg.sv
src/rmt_cell.sv
src/rmt_chain.sv
src/running_median_tracker.sv
src/rmt_checker.sv
tb/sv/median_checker.sv
tb/sv/tb_running_median_tracker.sv
